// ----- hw/rtl/hubwd_pkg.sv -----
`timescale 1ns / 1ps

package hubwd_pkg;

    // Tick counter width; the counter saturates at all ones
    localparam int TIMER_WIDTH = 20;

    // Register widths
    localparam int GRACE_W   = 20;
    localparam int PULSE_W   = 10;
    localparam int OBSERVE_W = 20;
    localparam int TRIES_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Common compare width for counter against limits
    localparam int CMP_W = (TIMER_WIDTH > GRACE_W) ? TIMER_WIDTH : GRACE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSERVE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIES   = 2'd3;

    // Register reset values
    localparam logic [GRACE_W-1:0]   GRACE_RST   = 20'd10000;
    localparam logic [PULSE_W-1:0]   PULSE_RST   = 10'd10;
    localparam logic [OBSERVE_W-1:0] OBSERVE_RST = 20'd3000;
    localparam logic [TRIES_W-1:0]   TRIES_RST   = 4'd2;

    // Item mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ARM  = 1'b1;

    typedef enum logic [1:0] {
        PH_GRACE   = 2'd0,
        PH_PULSE   = 2'd1,
        PH_OBSERVE = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [GRACE_W-1:0]   grace_ticks;
        logic [PULSE_W-1:0]   pulse_ticks;
        logic [OBSERVE_W-1:0] observe_ticks;
        logic [TRIES_W-1:0]   max_tries;
    } t_cfg;

    typedef struct packed {
        logic               hub_enable;
        t_phase             phase;
        logic [TRIES_W-1:0] attempts;
        logic               pulse_started;
        logic               gave_up;
    } t_result;

endpackage

// ----- hw/rtl/hub_enumeration_recovery_watchdog.sv -----
`timescale 1ns / 1ps
// A result word appears on the output in the cycle after its input word is accepted.
// Throughput: one word per cycle while no stall holds the input; the single state update
// and result register set the pace. Input stall follows output stall only while the
// result register is full. Reset (synchronous, active low) sets grace phase, zero count
// and attempts, clears the give-up flag and loads the register defaults.

module hub_enumeration_recovery_watchdog import hubwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic                 i_cold_boot,
    input  logic                 i_usb_mounted,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_hub_enable,
    output logic [1:0]           o_phase,
    output logic [TRIES_W-1:0]   o_attempts,
    output logic                 o_pulse_started,
    output logic                 o_gave_up,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    hubwd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    hubwd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_cold_boot   (i_cold_boot),
        .i_usb_mounted (i_usb_mounted),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    // Take a word whenever the result register is empty or drains this cycle
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hub_enable    = r_out.hub_enable;
    assign o_phase         = r_out.phase;
    assign o_attempts      = r_out.attempts;
    assign o_pulse_started = r_out.pulse_started;
    assign o_gave_up       = r_out.gave_up;

endmodule

// ----- hw/rtl/hubwd_cfg.sv -----
`timescale 1ns / 1ps

module hubwd_cfg import hubwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register file, written one register per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_ticks   <= GRACE_RST;
            r_cfg.pulse_ticks   <= PULSE_RST;
            r_cfg.observe_ticks <= OBSERVE_RST;
            r_cfg.max_tries     <= TRIES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRACE:   r_cfg.grace_ticks   <= i_cfg_wdata[GRACE_W-1:0];
                CFG_PULSE:   r_cfg.pulse_ticks   <= i_cfg_wdata[PULSE_W-1:0];
                CFG_OBSERVE: r_cfg.observe_ticks <= i_cfg_wdata[OBSERVE_W-1:0];
                CFG_TRIES:   r_cfg.max_tries     <= i_cfg_wdata[TRIES_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/hubwd_core.sv -----
`timescale 1ns / 1ps

module hubwd_core import hubwd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_mode,
    input  logic    i_cold_boot,
    input  logic    i_usb_mounted,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [TRIES_W-1:0]     r_attempts, n_attempts;
    logic                   r_gave_up, n_gave_up;
    logic                   started;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [CMP_W-1:0]       cmp_elapsed;

    // Saturating tick count
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIMER_WIDTH'(1);
    assign cmp_elapsed = CMP_W'(elapsed_inc);

    // Next state for one word
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_attempts = r_attempts;
        n_gave_up  = r_gave_up;
        started    = 1'b0;
        if (i_mode == MODE_ARM) begin
            if (i_cold_boot) begin
                n_attempts = '0;
            end
            n_phase   = PH_GRACE;
            n_elapsed = '0;
            n_gave_up = 1'b0;
        end else begin
            unique case (r_phase)
                PH_GRACE: begin
                    if (i_usb_mounted) begin
                        n_attempts = '0;
                        n_phase    = PH_DONE;
                    end else begin
                        n_elapsed = elapsed_inc;
                        if (cmp_elapsed >= CMP_W'(i_cfg.grace_ticks)) begin
                            if (r_attempts >= i_cfg.max_tries) begin
                                n_gave_up = 1'b1;
                                n_phase   = PH_DONE;
                            end else begin
                                // starting tick is the first low tick
                                n_attempts = r_attempts + TRIES_W'(1);
                                n_phase    = PH_PULSE;
                                n_elapsed  = '0;
                                started    = 1'b1;
                            end
                        end
                    end
                end
                PH_PULSE: begin
                    n_elapsed = elapsed_inc;
                    if (cmp_elapsed >= CMP_W'(i_cfg.pulse_ticks)) begin
                        n_phase   = PH_OBSERVE;
                        n_elapsed = '0;
                    end
                end
                PH_OBSERVE: begin
                    if (i_usb_mounted) begin
                        n_attempts = '0;
                        n_phase    = PH_DONE;
                    end else begin
                        n_elapsed = elapsed_inc;
                        if (cmp_elapsed > CMP_W'(i_cfg.observe_ticks)) begin
                            n_phase   = PH_GRACE;
                            n_elapsed = '0;
                        end
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    // State registers advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_GRACE;
            r_elapsed  <= '0;
            r_attempts <= '0;
            r_gave_up  <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_attempts <= n_attempts;
            r_gave_up  <= n_gave_up;
        end
    end

    // Result for this word
    always_comb begin
        o_result.hub_enable    = (n_phase != PH_PULSE);
        o_result.phase         = n_phase;
        o_result.attempts      = n_attempts;
        o_result.pulse_started = started;
        o_result.gave_up       = n_gave_up;
    end

endmodule

// ----- hw/rtl/hubwd_chk.sv -----
`timescale 1ns / 1ps

module hubwd_chk import hubwd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_hub_enable,
    input logic [1:0]           o_phase,
    input logic [TRIES_W-1:0]   o_attempts,
    input logic                 o_pulse_started,
    input logic                 o_gave_up
);

    // Hub reset line is low exactly while pulsing
    a_enable_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hub_enable == (o_phase != PH_PULSE)))
        else $error("hub_enable disagrees with phase");

    // A new pulse is always counted
    a_start_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pulse_started) |-> (o_phase == PH_PULSE && o_attempts != '0))
        else $error("pulse started without pulse phase or attempt");

    // Giving up only happens in the done phase
    a_gave_up_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gave_up) |-> (o_phase == PH_DONE))
        else $error("gave_up outside done phase");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_phase)
            && $stable(o_attempts) && $stable(o_gave_up)))
        else $error("stalled result word changed");

endmodule

bind hub_enumeration_recovery_watchdog hubwd_chk u_hubwd_chk (.*);

// ----- sim/hubwd_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the register port of the recovery watchdog,
// predicts each result word and compares it field by field.
module hubwd_checker import hubwd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_mode,
    input  logic                 i_cold_boot,
    input  logic                 i_usb_mounted,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_hub_enable,
    input  logic [1:0]           i_phase,
    input  logic [TRIES_W-1:0]   i_attempts,
    input  logic                 i_pulse_started,
    input  logic                 i_gave_up,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output int                   o_fail_cnt,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int MAX_PRINTS = 40;

    // predicted watchdog state and register copy
    t_phase                 wd_phase;
    logic [TIMER_WIDTH-1:0] tick_cnt;
    logic [TRIES_W-1:0]     retry_cnt;
    logic                   quit_flag;
    t_cfg                   cfg;

    // expected status words, oldest first
    t_result                expected_status[$];
    t_result                want;

    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // advance the predicted watchdog by one word and return its status
    function automatic t_result next_status(input logic mode, input logic cold,
                                            input logic mounted);
        t_result r;
        logic    started;
        started = 1'b0;
        if (mode == MODE_ARM) begin
            // arm: restart grace from any phase, cold boot forgets attempts
            if (cold) retry_cnt = '0;
            wd_phase  = PH_GRACE;
            tick_cnt  = '0;
            quit_flag = 1'b0;
        end else begin
            case (wd_phase)
                PH_GRACE: begin
                    if (mounted) begin
                        retry_cnt = '0;
                        wd_phase  = PH_DONE;
                    end else begin
                        tick_cnt = sat_inc(tick_cnt);
                        if (tick_cnt >= cfg.grace_ticks) begin
                            if (retry_cnt >= cfg.max_tries) begin
                                quit_flag = 1'b1;
                                wd_phase  = PH_DONE;
                            end else begin
                                // this tick is the first low tick of the pulse
                                retry_cnt = retry_cnt + 1'b1;
                                wd_phase  = PH_PULSE;
                                tick_cnt  = '0;
                                started   = 1'b1;
                            end
                        end
                    end
                end
                PH_PULSE: begin
                    // mount is ignored; the pulse always runs out
                    tick_cnt = sat_inc(tick_cnt);
                    if (tick_cnt >= TIMER_WIDTH'(cfg.pulse_ticks)) begin
                        wd_phase = PH_OBSERVE;
                        tick_cnt = '0;
                    end
                end
                PH_OBSERVE: begin
                    if (mounted) begin
                        retry_cnt = '0;
                        wd_phase  = PH_DONE;
                    end else begin
                        tick_cnt = sat_inc(tick_cnt);
                        if (tick_cnt > cfg.observe_ticks) begin
                            wd_phase = PH_GRACE;
                            tick_cnt = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.hub_enable    = (wd_phase != PH_PULSE);
        r.phase         = wd_phase;
        r.attempts      = retry_cnt;
        r.pulse_started = started;
        r.gave_up       = quit_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (o_fail_cnt < MAX_PRINTS)
            $display("MISMATCH at %0t, word %0d: %s", $time, o_checked, what);
        o_fail_cnt++;
    endtask

    // monitor: register writes, result compare, then input prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wd_phase          = PH_GRACE;
            tick_cnt          = '0;
            retry_cnt         = '0;
            quit_flag         = 1'b0;
            cfg.grace_ticks   = GRACE_RST;
            cfg.pulse_ticks   = PULSE_RST;
            cfg.observe_ticks = OBSERVE_RST;
            cfg.max_tries     = TRIES_RST;
            expected_status.delete();
            o_fail_cnt        = 0;
            o_checked         = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRACE:   cfg.grace_ticks   = i_cfg_wdata[GRACE_W-1:0];
                    CFG_PULSE:   cfg.pulse_ticks   = i_cfg_wdata[PULSE_W-1:0];
                    CFG_OBSERVE: cfg.observe_ticks = i_cfg_wdata[OBSERVE_W-1:0];
                    CFG_TRIES:   cfg.max_tries     = i_cfg_wdata[TRIES_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_status.pop_front();
                    if (i_hub_enable !== want.hub_enable)
                        report_mismatch($sformatf("hub_enable exp %0b got %0b",
                                                  want.hub_enable, i_hub_enable));
                    if (i_phase !== want.phase)
                        report_mismatch($sformatf("phase exp %0d got %0d",
                                                  want.phase, i_phase));
                    if (i_attempts !== want.attempts)
                        report_mismatch($sformatf("attempts exp %0d got %0d",
                                                  want.attempts, i_attempts));
                    if (i_pulse_started !== want.pulse_started)
                        report_mismatch($sformatf("pulse_started exp %0b got %0b",
                                                  want.pulse_started, i_pulse_started));
                    if (i_gave_up !== want.gave_up)
                        report_mismatch($sformatf("gave_up exp %0b got %0b",
                                                  want.gave_up, i_gave_up));
                    o_checked++;
                end
            end

            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                expected_status.push_back(next_status(i_mode, i_cold_boot, i_usb_mounted));
        end
        o_pending = expected_status.size();
    end

endmodule

// ----- sim/tb_hub_enumeration_recovery_watchdog.sv -----
`timescale 1ns / 1ps

module tb_hub_enumeration_recovery_watchdog;
    import hubwd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int N_SETTINGS    = 8;
    localparam int WORDS_PER_SET = 100;
    localparam int LONG_HOLD     = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_mode;
    logic                 i_cold_boot;
    logic                 i_usb_mounted;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_hub_enable;
    logic [1:0]           o_phase;
    logic [TRIES_W-1:0]   o_attempts;
    logic                 o_pulse_started;
    logic                 o_gave_up;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;

    int n_fail;
    int n_pending;
    int n_checked;
    int words_sent    = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_pct      = 0;
    bit long_hold     = 1'b0;

    hub_enumeration_recovery_watchdog dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_cold_boot     (i_cold_boot),
        .i_usb_mounted   (i_usb_mounted),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hub_enable    (o_hub_enable),
        .o_phase         (o_phase),
        .o_attempts      (o_attempts),
        .o_pulse_started (o_pulse_started),
        .o_gave_up       (o_gave_up),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    hubwd_checker wd_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_cold_boot     (i_cold_boot),
        .i_usb_mounted   (i_usb_mounted),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hub_enable    (o_hub_enable),
        .i_phase         (o_phase),
        .i_attempts      (o_attempts),
        .i_pulse_started (o_pulse_started),
        .i_gave_up       (o_gave_up),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_cnt      (n_fail),
        .o_pending       (n_pending),
        .o_checked       (n_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, n_pending);
            $display("tb_hub_enumeration_recovery_watchdog NOT OK");
            $finish;
        end
    end

    // result side: random stall, or one long hold when asked
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // offer one word, hold it until taken; entered and left at a falling edge
    task automatic send_word(input logic mode, input logic cold, input logic mounted);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_cold_boot   <= cold;
        i_usb_mounted <= mounted;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic tick_word(input logic mounted);
        send_word(MODE_TICK, 1'($urandom_range(1)), mounted);
    endtask

    task automatic arm_word(input logic cold);
        send_word(MODE_ARM, cold, 1'($urandom_range(1)));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (n_pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // write all four registers, one per cycle, block idle
    task automatic program_watchdog(input t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GRACE;
        i_cfg_wdata <= CFG_DAT_W'(c.grace_ticks);
        @(negedge i_clk);
        i_cfg_index <= CFG_PULSE;
        i_cfg_wdata <= CFG_DAT_W'(c.pulse_ticks);
        @(negedge i_clk);
        i_cfg_index <= CFG_OBSERVE;
        i_cfg_wdata <= CFG_DAT_W'(c.observe_ticks);
        @(negedge i_clk);
        i_cfg_index <= CFG_TRIES;
        i_cfg_wdata <= CFG_DAT_W'(c.max_tries);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // register settings for the random phases, extremes included
    function automatic t_cfg watchdog_setting(input int k);
        t_cfg c;
        case (k)
            0: c = '{grace_ticks: 20'd3,       pulse_ticks: 10'd2,    observe_ticks: 20'd2,
                     max_tries: 4'd3};
            1: c = '{grace_ticks: 20'd0,       pulse_ticks: 10'd0,    observe_ticks: 20'd0,
                     max_tries: 4'd15};
            2: c = '{grace_ticks: 20'd1,       pulse_ticks: 10'd1,    observe_ticks: 20'd0,
                     max_tries: 4'd0};
            3: c = '{grace_ticks: 20'd5,       pulse_ticks: 10'd4,    observe_ticks: 20'd6,
                     max_tries: 4'd2};
            4: c = '{grace_ticks: 20'hFFFFF,   pulse_ticks: 10'd1,    observe_ticks: 20'd3,
                     max_tries: 4'd1};
            5: c = '{grace_ticks: 20'd2,       pulse_ticks: 10'd1023, observe_ticks: 20'd4,
                     max_tries: 4'd1};
            6: c = '{grace_ticks: 20'd2,       pulse_ticks: 10'd3,    observe_ticks: 20'hFFFFF,
                     max_tries: 4'd4};
            default: c = '{grace_ticks: 20'd4, pulse_ticks: 10'd2,    observe_ticks: 20'd3,
                     max_tries: 4'd15};
        endcase
        return c;
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_mode        = MODE_TICK;
        i_cold_boot   = 1'b0;
        i_usb_mounted = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GRACE;
        i_cfg_wdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: grace 2, pulse 2, observe 1, one try
        program_watchdog('{grace_ticks: 20'd2, pulse_ticks: 10'd2, observe_ticks: 20'd1,
                           max_tries: 4'd1});
        arm_word(1'b1);
        send_word(MODE_TICK, 1'b1, 1'b0);   // cold boot on a tick is ignored
        tick_word(1'b0);                    // grace expires, pulse starts
        tick_word(1'b1);                    // mount during pulse ignored
        tick_word(1'b0);                    // pulse ends
        tick_word(1'b0);
        tick_word(1'b0);                    // observe window over, back to grace
        tick_word(1'b0);
        tick_word(1'b0);                    // budget used up: give up
        tick_word(1'b1);                    // done ignores ticks
        arm_word(1'b0);                     // warm arm keeps the attempt count
        tick_word(1'b0);
        tick_word(1'b0);
        arm_word(1'b1);                     // cold arm clears it
        tick_word(1'b0);
        tick_word(1'b0);
        arm_word(1'b0);                     // arm in the middle of a pulse
        tick_word(1'b1);                    // mount in grace
        arm_word(1'b1);
        tick_word(1'b0);
        tick_word(1'b0);
        tick_word(1'b0);
        tick_word(1'b0);
        tick_word(1'b1);                    // mount in observe
        drain(2);

        // random phases: one register setting and one idle mix each
        for (int k = 0; k < N_SETTINGS; k++) begin
            program_watchdog(watchdog_setting(k));
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_pct = 0;  end
                1: begin send_idle_pct = 67; recv_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_pct = 67; end
                default: begin send_idle_pct = 37; recv_pct = 37; end
            endcase
            for (int n = 0; n < WORDS_PER_SET; n++) begin
                if (k == 0 && n == 30)
                    long_hold = 1'b1;
                if (k == 0 && n == 70)
                    drain(0);
                if ($urandom_range(99) < 6)
                    arm_word(1'($urandom_range(1)));
                else
                    tick_word($urandom_range(99) < 4);
            end
            drain(2);
        end

        recv_pct = 0;
        drain(4);
        $display("covered %0d words, %0d results checked over %0d register settings,",
                 words_sent, n_checked, N_SETTINGS + 1);
        $display("with idle and stall mixes, one long output hold and an input pause");
        if (n_fail == 0 && n_pending == 0)
            $display("tb_hub_enumeration_recovery_watchdog OK");
        else
            $display("tb_hub_enumeration_recovery_watchdog NOT OK");
        $finish;
    end

endmodule

// ----- hub_enumeration_recovery_watchdog.f -----
hw/rtl/hubwd_pkg.sv
hw/rtl/hubwd_cfg.sv
hw/rtl/hubwd_core.sv
hw/rtl/hub_enumeration_recovery_watchdog.sv
hw/rtl/hubwd_chk.sv
sim/hubwd_checker.sv
sim/tb_hub_enumeration_recovery_watchdog.sv
